### rtl/core/clock_aligned_sensor_averager_macros.svh
// Assertion macros for the checker of the sensor averager.
`ifndef CLOCK_ALIGNED_SENSOR_AVERAGER_MACROS_SVH
`define CLOCK_ALIGNED_SENSOR_AVERAGER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cas_pkg.sv
// Types, constants and state codes of the clock aligned sensor averager.
package cas_pkg;

  localparam int unsigned DAY_ENTRIES_DEF = 72;

  localparam int unsigned NOW_W    = 32;
  localparam int unsigned OFFS_W   = 17;
  localparam int unsigned HIDX_W   = 7;
  localparam int unsigned PSAMP_W  = 32;
  localparam int unsigned TSAMP_W  = 16;
  localparam int unsigned PAVG_W   = 23;
  localparam int unsigned TAVG_W   = 16;
  localparam int unsigned MPSUM_W  = 40;
  localparam int unsigned LPSUM_W  = 48;
  localparam int unsigned TSUM_W   = 32;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned PDIV_W   = 18;

  localparam int unsigned SHORT_PERIOD   = 10;
  localparam int unsigned MINUTE_PERIOD  = 60;
  localparam int unsigned LONG_PERIOD    = 20 * 60;
  localparam int unsigned PRESSURE_SCALE = 1000;

  localparam int unsigned SRW = $clog2(SHORT_PERIOD);
  localparam int unsigned MRW = $clog2(MINUTE_PERIOD);
  localparam int unsigned LRW = $clog2(LONG_PERIOD);

  // Bias is a multiple of every period and larger than any offset magnitude,
  // so the biased time is never negative and fits ALIGN_W bits.
  localparam int unsigned ALIGN_W    = 33;
  localparam int unsigned ALIGN_BIAS = 55 * LONG_PERIOD;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [0:0] {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FOLD,
    ST_LONG,
    ST_WAIT,
    ST_STORE,
    ST_READ,
    ST_FIN
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [NOW_W-1:0]    now_seconds;
    logic [PSAMP_W-1:0]  pressure_sample;
    logic [TSAMP_W-1:0]  temperature_sample;
    logic [TSAMP_W-1:0]  humidity_sample;
    logic [HIDX_W-1:0]   history_index;
  } in_t;

  typedef struct packed {
    logic                sample_taken;
    logic                minute_done;
    logic                period_done;
    logic [PAVG_W-1:0]   minute_pressure;
    logic [TAVG_W-1:0]   minute_temperature;
    logic [TAVG_W-1:0]   minute_humidity;
    logic [PAVG_W-1:0]   entry_pressure;
    logic [TAVG_W-1:0]   entry_temperature;
    logic [TAVG_W-1:0]   entry_humidity;
    logic                new_entry_ready;
  } out_t;

  typedef struct packed {
    logic [PAVG_W-1:0]   pressure;
    logic [TAVG_W-1:0]   temperature;
    logic [TAVG_W-1:0]   humidity;
  } entry_t;

  typedef struct packed {
    logic                push;
    logic                rd_en;
    logic                rd_newest;
    logic [HIDX_W-1:0]   rd_index;
  } hist_req_t;

endpackage

### rtl/core/cas_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module cas_div
  import cas_pkg::*;
#(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] acc_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fit;

  // Shift the next dividend bit into the partial remainder, try a subtract.
  always_comb begin
    trial = {rem_q, acc_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    fit   = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fit ? diff[VW-1:0] : trial[VW-1:0];
      acc_q <= {acc_q[DW-2:0], fit};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = acc_q;

endmodule

### rtl/core/cas_align.sv
// Alarm alignment: bit-serial remainders of the biased local time.
module cas_align
  import cas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NOW_W-1:0]  now_i,
  input  logic [OFFS_W-1:0] offset_i,
  output logic              busy_o,
  output logic [NOW_W-1:0]  short_o,
  output logic [NOW_W-1:0]  minute_o,
  output logic [NOW_W-1:0]  long_o
);

  localparam int unsigned CW = $clog2(ALIGN_W + 1);

  logic [ALIGN_W-1:0] sh_q;
  logic [SRW-1:0]     rs_q;
  logic [MRW-1:0]     rm_q;
  logic [LRW-1:0]     rl_q;
  logic [CW-1:0]      cnt_q;
  logic [ALIGN_W:0]   biased;
  logic [SRW:0]       ts;
  logic [MRW:0]       tm;
  logic [LRW:0]       tl;
  logic [SRW:0]       ns;
  logic [MRW:0]       nm;
  logic [LRW:0]       nl;

  always_comb begin
    biased = {2'b00, now_i}
           + {{(ALIGN_W + 1 - OFFS_W){offset_i[OFFS_W-1]}}, offset_i}
           + (ALIGN_W + 1)'(ALIGN_BIAS);
    ts = {rs_q, sh_q[ALIGN_W-1]};
    tm = {rm_q, sh_q[ALIGN_W-1]};
    tl = {rl_q, sh_q[ALIGN_W-1]};
    ns = (ts >= (SRW + 1)'(SHORT_PERIOD))  ? ts - (SRW + 1)'(SHORT_PERIOD)  : ts;
    nm = (tm >= (MRW + 1)'(MINUTE_PERIOD)) ? tm - (MRW + 1)'(MINUTE_PERIOD) : tm;
    nl = (tl >= (LRW + 1)'(LONG_PERIOD))   ? tl - (LRW + 1)'(LONG_PERIOD)   : tl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(ALIGN_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= biased[ALIGN_W-1:0];
      rs_q <= '0;
      rm_q <= '0;
      rl_q <= '0;
    end else if (cnt_q != '0) begin
      sh_q <= {sh_q[ALIGN_W-2:0], 1'b0};
      rs_q <= ns[SRW-1:0];
      rm_q <= nm[MRW-1:0];
      rl_q <= nl[LRW-1:0];
    end
  end

  assign busy_o   = (cnt_q != '0);
  assign short_o  = now_i + NOW_W'(SHORT_PERIOD)  - NOW_W'(rs_q);
  assign minute_o = now_i + NOW_W'(MINUTE_PERIOD) - NOW_W'(rm_q);
  assign long_o   = now_i + NOW_W'(LONG_PERIOD)   - NOW_W'(rl_q);

endmodule

### rtl/core/cas_hist.sv
// History store: circular memory with a fill count standing in for the clear.
module cas_hist
  import cas_pkg::*;
#(
  parameter int unsigned DEPTH = DAY_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hist_req_t req_i,
  input  entry_t    push_data_i,
  output entry_t    rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW = (AW > HIDX_W) ? AW : HIDX_W;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  entry_t        rd_q;
  logic          ok_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [IW-1:0] lidx;
  logic [IW:0]   psum;
  logic [IW:0]   pwrap;
  logic          in_range;
  logic          filled;

  // Logical index 0 is the oldest slot, which is the one head points at.
  always_comb begin
    lidx     = req_i.rd_newest ? IW'(DEPTH - 1) : IW'(req_i.rd_index);
    in_range = {1'b0, lidx} < (IW + 1)'(DEPTH);
    filled   = ({1'b0, lidx} + (IW + 1)'(fill_q)) >= (IW + 1)'(DEPTH);
    psum     = (IW + 1)'(head_q) + {1'b0, lidx};
    pwrap    = (psum >= (IW + 1)'(DEPTH)) ? psum - (IW + 1)'(DEPTH) : psum;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[head_q] <= push_data_i;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[pwrap[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      ok_q   <= 1'b0;
    end else begin
      if (req_i.push) begin
        head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        if (fill_q != FW'(DEPTH)) begin
          fill_q <= fill_q + FW'(1);
        end
      end
      if (req_i.rd_en) begin
        ok_q <= in_range && filled;
      end
    end
  end

  // Never-written slots read back as the cleared value.
  assign rd_data_o = ok_q ? rd_q : '0;

endmodule

### rtl/core/clock_aligned_sensor_averager.sv
// Top level of the clock aligned sensor averager.
//
//   channel  direction  handshake                 word type
//   in       input      in_valid_i / in_stall_o   in_t
//   out      output     out_valid_o / out_stall_i out_t
//   cfg      input      cfg_we_i (no wait)        17-bit signed offset
//
// One word at a time. Beyond the evaluate, history read and result steps, an
// arming or sampling tick waits on the 33-step alarm alignment, a minute tick
// on the 40-step minute pressure divider and a 20-minute tick on the 48-step
// long pressure divider. The input reopens the cycle after the result loads;
// a full, stalled result register holds the item in its last step. Reset
// clears all sums, alarms and the history fill count.
module clock_aligned_sensor_averager
  import cas_pkg::*;
#(
  parameter int unsigned DAY_ENTRIES = DAY_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_word_o,
  input  logic              cfg_we_i,
  input  logic [OFFS_W-1:0] cfg_data_i
);

  // Control.
  state_e            state_q, state_d;
  in_t               in_q;
  logic [OFFS_W-1:0] offset_q;
  logic              armed_q;
  logic              arm_q, s_fired_q, m_fired_q, l_fired_q;
  logic              new_flag_q, flag_before_q;

  // Alarms and running sums.
  logic [NOW_W-1:0]   short_alarm_q, minute_alarm_q, long_alarm_q;
  logic [MPSUM_W-1:0] mps_q;
  logic [TSUM_W-1:0]  mts_q, mhs_q;
  logic [CNT_W-1:0]   mcnt_q;
  logic [LPSUM_W-1:0] lps_q;
  logic [TSUM_W-1:0]  lts_q, lhs_q;
  logic [CNT_W-1:0]   lcnt_q;
  logic [CNT_W-1:0]   mdiv_cnt_q, ldiv_cnt_q;
  entry_t             minute_avg_q;

  // Result register.
  out_t out_q;
  logic out_valid_q;

  // Strobes.
  logic is_tick, s_hit, m_hit, l_hit;
  logic align_start, mdiv_start, ldiv_start, out_load, fold_ok;
  logic units_busy;

  // Unit signals.
  logic              align_busy;
  logic [NOW_W-1:0]  al_short, al_minute, al_long;
  logic [PDIV_W-1:0] mp_dvs, lp_dvs;
  logic [MPSUM_W-1:0] mp_quot;
  logic [LPSUM_W-1:0] lp_quot;
  logic [TSUM_W-1:0]  mt_quot, mh_quot, lt_quot, lh_quot;
  logic mp_busy, mt_busy, mh_busy, lp_busy, lt_busy, lh_busy;
  entry_t    long_avg, minute_avg_new, hist_rd;
  hist_req_t hreq;

  // Alarm tests: minute only behind the 10 s alarm, long only behind minute.
  always_comb begin
    is_tick = (in_q.kind == KIND_TICK);
    s_hit   = in_q.now_seconds >= short_alarm_q;
    m_hit   = s_hit && (in_q.now_seconds >= minute_alarm_q);
    l_hit   = m_hit && (in_q.now_seconds >= long_alarm_q);
    fold_ok = ({1'b0, lcnt_q} + {1'b0, mcnt_q}) <= {1'b0, COUNT_MAX};
    units_busy = align_busy || mp_busy || mt_busy || mh_busy
              || lp_busy || lt_busy || lh_busy;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (!is_tick) begin
          state_d = ST_READ;
        end else if (!armed_q) begin
          state_d = ST_WAIT;
        end else if (m_hit) begin
          state_d = ST_FOLD;
        end else if (s_hit) begin
          state_d = ST_WAIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_FOLD:  state_d = l_fired_q ? ST_LONG : ST_WAIT;
      ST_LONG:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (!units_busy) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: state_d = ST_READ;
      ST_READ:  state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Strobes from the state.
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    align_start    = (state_q == ST_EVAL) && is_tick && (!armed_q || s_hit);
    mdiv_start     = (state_q == ST_FOLD);
    ldiv_start     = (state_q == ST_LONG);
    out_load       = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
    hreq.push      = (state_q == ST_STORE) && l_fired_q;
    hreq.rd_en     = (state_q == ST_READ);
    hreq.rd_newest = is_tick;
    hreq.rd_index  = in_q.history_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted word for the whole item.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  // Averages; a zero count gives zero.
  always_comb begin
    mp_dvs = PDIV_W'(mcnt_q) * PDIV_W'(PRESSURE_SCALE);
    lp_dvs = PDIV_W'(lcnt_q) * PDIV_W'(PRESSURE_SCALE);
    if (mdiv_cnt_q == '0) begin
      minute_avg_new = '0;
    end else begin
      minute_avg_new.pressure    = mp_quot[PAVG_W-1:0];
      minute_avg_new.temperature = mt_quot[TAVG_W-1:0];
      minute_avg_new.humidity    = mh_quot[TAVG_W-1:0];
    end
    if (ldiv_cnt_q == '0) begin
      long_avg = '0;
    end else begin
      long_avg.pressure    = lp_quot[PAVG_W-1:0];
      long_avg.temperature = lt_quot[TAVG_W-1:0];
      long_avg.humidity    = lh_quot[TAVG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q       <= '0;
      armed_q        <= 1'b0;
      arm_q          <= 1'b0;
      s_fired_q      <= 1'b0;
      m_fired_q      <= 1'b0;
      l_fired_q      <= 1'b0;
      new_flag_q     <= 1'b0;
      flag_before_q  <= 1'b0;
      short_alarm_q  <= '0;
      minute_alarm_q <= '0;
      long_alarm_q   <= '0;
      mps_q          <= '0;
      mts_q          <= '0;
      mhs_q          <= '0;
      mcnt_q         <= '0;
      lps_q          <= '0;
      lts_q          <= '0;
      lhs_q          <= '0;
      lcnt_q         <= '0;
      mdiv_cnt_q     <= '0;
      ldiv_cnt_q     <= '0;
      minute_avg_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_EVAL: begin
          flag_before_q <= new_flag_q;
          arm_q         <= is_tick && !armed_q;
          s_fired_q     <= is_tick && armed_q && s_hit;
          m_fired_q     <= is_tick && armed_q && m_hit;
          l_fired_q     <= is_tick && armed_q && l_hit;
          if (!is_tick) begin
            new_flag_q <= 1'b0;
          end
          if (is_tick && !armed_q) begin
            armed_q <= 1'b1;
          end
          // Take the sample; drop it once the minute count is full.
          if (is_tick && armed_q && s_hit && (mcnt_q != COUNT_MAX)) begin
            mps_q  <= mps_q + MPSUM_W'(in_q.pressure_sample);
            mts_q  <= mts_q + TSUM_W'(in_q.temperature_sample);
            mhs_q  <= mhs_q + TSUM_W'(in_q.humidity_sample);
            mcnt_q <= mcnt_q + CNT_W'(1);
          end
        end
        ST_FOLD: begin
          mdiv_cnt_q <= mcnt_q;
          // Fold the minute sums in, or drop them if the long count would overflow.
          if (fold_ok) begin
            lps_q  <= lps_q + LPSUM_W'(mps_q);
            lts_q  <= lts_q + mts_q;
            lhs_q  <= lhs_q + mhs_q;
            lcnt_q <= lcnt_q + mcnt_q;
          end
          mps_q  <= '0;
          mts_q  <= '0;
          mhs_q  <= '0;
          mcnt_q <= '0;
        end
        ST_LONG: begin
          ldiv_cnt_q <= lcnt_q;
          lps_q      <= '0;
          lts_q      <= '0;
          lhs_q      <= '0;
          lcnt_q     <= '0;
        end
        ST_STORE: begin
          if (arm_q || s_fired_q) begin
            short_alarm_q <= al_short;
          end
          if (arm_q || m_fired_q) begin
            minute_alarm_q <= al_minute;
          end
          if (arm_q || l_fired_q) begin
            long_alarm_q <= al_long;
          end
          if (m_fired_q) begin
            minute_avg_q <= minute_avg_new;
          end
          if (l_fired_q) begin
            new_flag_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load when free or being taken, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.sample_taken       <= s_fired_q;
      out_q.minute_done        <= m_fired_q;
      out_q.period_done        <= l_fired_q;
      out_q.minute_pressure    <= minute_avg_q.pressure;
      out_q.minute_temperature <= minute_avg_q.temperature;
      out_q.minute_humidity    <= minute_avg_q.humidity;
      out_q.entry_pressure     <= hist_rd.pressure;
      out_q.entry_temperature  <= hist_rd.temperature;
      out_q.entry_humidity     <= hist_rd.humidity;
      out_q.new_entry_ready    <= flag_before_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  cas_align u_align (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (align_start),
    .now_i    (in_q.now_seconds),
    .offset_i (offset_q),
    .busy_o   (align_busy),
    .short_o  (al_short),
    .minute_o (al_minute),
    .long_o   (al_long)
  );

  cas_div #(.DW(MPSUM_W), .VW(PDIV_W)) u_div_mp (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (mdiv_start),
    .dividend_i (mps_q), .divisor_i (mp_dvs), .busy_o (mp_busy), .quot_o (mp_quot)
  );

  cas_div #(.DW(TSUM_W), .VW(CNT_W)) u_div_mt (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (mdiv_start),
    .dividend_i (mts_q), .divisor_i (mcnt_q), .busy_o (mt_busy), .quot_o (mt_quot)
  );

  cas_div #(.DW(TSUM_W), .VW(CNT_W)) u_div_mh (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (mdiv_start),
    .dividend_i (mhs_q), .divisor_i (mcnt_q), .busy_o (mh_busy), .quot_o (mh_quot)
  );

  cas_div #(.DW(LPSUM_W), .VW(PDIV_W)) u_div_lp (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (ldiv_start),
    .dividend_i (lps_q), .divisor_i (lp_dvs), .busy_o (lp_busy), .quot_o (lp_quot)
  );

  cas_div #(.DW(TSUM_W), .VW(CNT_W)) u_div_lt (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (ldiv_start),
    .dividend_i (lts_q), .divisor_i (lcnt_q), .busy_o (lt_busy), .quot_o (lt_quot)
  );

  cas_div #(.DW(TSUM_W), .VW(CNT_W)) u_div_lh (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (ldiv_start),
    .dividend_i (lhs_q), .divisor_i (lcnt_q), .busy_o (lh_busy), .quot_o (lh_quot)
  );

  cas_hist #(.DEPTH(DAY_ENTRIES)) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (hreq),
    .push_data_i (long_avg),
    .rd_data_o   (hist_rd)
  );

endmodule

### rtl/core/cas_checker.sv
// Port-level checker of the clock aligned sensor averager, bound to the top.
`include "clock_aligned_sensor_averager_macros.svh"

module cas_checker
  import cas_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_word_o
);

  // Stalled result holds.
  `CAS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `CAS_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word_o), "stalled word changed")

  // Alarms nest: a 20 minute push implies a minute update implies a sample.
  `CAS_ASSERT_SAME(a_period_nest, out_valid_o && out_word_o.period_done, out_word_o.minute_done, "period without minute")
  `CAS_ASSERT_SAME(a_minute_nest, out_valid_o && out_word_o.minute_done, out_word_o.sample_taken, "minute without sample")

endmodule

bind clock_aligned_sensor_averager cas_checker u_cas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
